>>> rtl/bir_pkg.sv
// bir_pkg: shared constants and types for the bilinear image resize block
// field widths, parameter defaults, reset values, opcode and register index codes
// no dependencies
package bir_pkg;

  // parameter defaults
  localparam int DEF_MAX_DIM    = 1024;
  localparam int DEF_PIXEL_BITS = 16;
  localparam int DEF_FRAC_BITS  = 16;

  // fixed port widths
  localparam int LOAD_VAL_W = 16;
  localparam int LOAD_IDX_W = 10;
  localparam int DEST_W     = 16;
  localparam int SIZE_W     = 11;
  localparam int STEP_W     = 27;
  localparam int OUT_W      = 16;

  // configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // source position is Q16 whatever the weight precision
  localparam int Q_FRAC = 16;
  localparam int Q_ONE  = 65536;

  // register reset values
  localparam int RST_SIZE = 1;
  localparam int RST_STEP = 65536;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_COMPUTE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    REG_SRC_W  = 2'd0,
    REG_SRC_H  = 2'd1,
    REG_STEP_X = 2'd2,
    REG_STEP_Y = 2'd3
  } cfg_reg_t;

endpackage

>>> rtl/bilinear_image_resize.sv
// bilinear_image_resize: pipelined half-pixel-centred bilinear scaler
// with a frame store split into four row/column parity banks
// depends on bir_pkg
//
//   channel   handshake                         payload
//   input     start & !busy at clock edge       in_opcode, in_load_*, in_dest_*
//   result    out_valid strobe, one cycle       out_pixel
//   config    psel & penable & pwrite & pready  paddr, pwdata, prdata
//
// one request per clock; busy is always low and the pipeline never stalls
// a compute request raises out_valid once it has passed the stages below and the output register
// stages: coordinate multiply, index clamp, bank access, row blend,
// column partial products, sum with rounding; loads write at the bank stage
// synchronous active-low reset clears valid bits and configuration registers, not the store
// the frame store holds whatever was loaded and is never cleared
module bilinear_image_resize
  import bir_pkg::*;
#(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_opcode,
  input  logic [LOAD_VAL_W-1:0] in_load_value,
  input  logic [LOAD_IDX_W-1:0] in_load_col,
  input  logic [LOAD_IDX_W-1:0] in_load_row,
  input  logic [DEST_W-1:0]     in_dest_col,
  input  logic [DEST_W-1:0]     in_dest_row,
  output logic                  out_valid,
  output logic [OUT_W-1:0]      out_pixel,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IDX_W      = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
  localparam int HALF_W     = (IDX_W > 1) ? IDX_W - 1 : 1;
  localparam int BANK_DEPTH = 1 << (2 * HALF_W);
  localparam int SZ_W       = $clog2(MAX_DIM + 1);
  localparam int U_W        = DEST_W + 1 + STEP_W;
  localparam int U1_W       = U_W + 1;
  localparam int T_W        = U_W - Q_FRAC;
  localparam int V_W        = PIXEL_BITS + FRAC_BITS;
  localparam int ACC_W      = PIXEL_BITS + 2 * FRAC_BITS + 1;
  localparam int RES_W      = PIXEL_BITS + 2;

  localparam logic [SZ_W-1:0]    MAX_SZ   = SZ_W'(MAX_DIM);
  localparam logic [FRAC_BITS:0] ONE_W    = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [ACC_W:0]     RND_HALF =
    {{(PIXEL_BITS + 2){1'b0}}, 1'b1, {(2 * FRAC_BITS - 1){1'b0}}};
  localparam logic [RES_W-1:0]   PIX_MAX  = {2'b00, {PIXEL_BITS{1'b1}}};

  typedef struct packed {
    logic [IDX_W-1:0]     i0;
    logic [IDX_W-1:0]     i1;
    logic [FRAC_BITS-1:0] w;
  } axis_t;

  // floor((u + 1.0) / 2) in Q16 gives position + 1; indices clamp to the edge
  function automatic axis_t axis_sample(input logic [U_W-1:0] u,
                                        input logic [SZ_W-1:0] sz);
    logic [U1_W-1:0]             sum;
    logic [U_W-1:0]              q;
    logic [T_W-1:0]              t;
    logic [T_W-1:0]              szx;
    logic [T_W-1:0]              last;
    logic [FRAC_BITS+Q_FRAC-1:0] fext;
    axis_t                       a;
    sum  = {1'b0, u} + U1_W'(Q_ONE);
    q    = sum[U1_W-1:1];
    t    = q[U_W-1:Q_FRAC];
    szx  = T_W'(sz);
    last = szx - T_W'(1);
    a.i1 = (t >= szx) ? IDX_W'(last) : IDX_W'(t);
    if (t > szx) begin
      a.i0 = IDX_W'(last);
    end else if (t == '0) begin
      a.i0 = '0;
    end else begin
      a.i0 = IDX_W'(t - T_W'(1));
    end
    fext = {q[Q_FRAC-1:0], {FRAC_BITS{1'b0}}};
    a.w  = fext[FRAC_BITS+Q_FRAC-1:Q_FRAC];
    return a;
  endfunction

  // ---------------- configuration registers ----------------
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_src_w_r, cfg_src_h_r;
  logic [STEP_W-1:0] cfg_step_x_r, cfg_step_y_r;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_src_w_r  <= SIZE_W'(RST_SIZE);
      cfg_src_h_r  <= SIZE_W'(RST_SIZE);
      cfg_step_x_r <= STEP_W'(RST_STEP);
      cfg_step_y_r <= STEP_W'(RST_STEP);
    end else if (cfg_we) begin
      case (cfg_reg_t'(paddr[3:2]))
        REG_SRC_W:  cfg_src_w_r  <= SIZE_W'(pwdata);
        REG_SRC_H:  cfg_src_h_r  <= SIZE_W'(pwdata);
        REG_STEP_X: cfg_step_x_r <= STEP_W'(pwdata);
        REG_STEP_Y: cfg_step_y_r <= STEP_W'(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_t'(paddr[3:2]))
      REG_SRC_W:  prdata = CFG_DATA_W'(cfg_src_w_r);
      REG_SRC_H:  prdata = CFG_DATA_W'(cfg_src_h_r);
      REG_STEP_X: prdata = CFG_DATA_W'(cfg_step_x_r);
      REG_STEP_Y: prdata = CFG_DATA_W'(cfg_step_y_r);
      default:    prdata = '0;
    endcase
  end

  // ---------------- stage 1: request capture ----------------
  logic                  accept;
  logic                  st1_valid_r, st1_compute_r;
  logic [LOAD_VAL_W-1:0] st1_value_r;
  logic [LOAD_IDX_W-1:0] st1_col_r, st1_row_r;
  logic [DEST_W-1:0]     st1_dcol_r, st1_drow_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_valid_r <= 1'b0;
    end else begin
      st1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st1_compute_r <= (in_opcode == OP_COMPUTE);
      st1_value_r   <= in_load_value;
      st1_col_r     <= in_load_col;
      st1_row_r     <= in_load_row;
      st1_dcol_r    <= in_dest_col;
      st1_drow_r    <= in_dest_row;
    end
  end

  // (2d + 1) * step: twice the position plus one, in Q16
  logic [U_W-1:0] ux_nxt, uy_nxt;
  logic           wr_ok_nxt;

  assign ux_nxt    = {st1_dcol_r, 1'b1} * cfg_step_x_r;
  assign uy_nxt    = {st1_drow_r, 1'b1} * cfg_step_y_r;
  assign wr_ok_nxt = (32'(st1_col_r) < MAX_DIM) && (32'(st1_row_r) < MAX_DIM);

  // ---------------- stage 2: clamp and weights ----------------
  logic                  st2_valid_r, st2_compute_r, st2_wr_ok_r;
  logic [U_W-1:0]        st2_ux_r, st2_uy_r;
  logic [PIXEL_BITS-1:0] st2_value_r;
  logic [IDX_W-1:0]      st2_col_r, st2_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st2_valid_r <= 1'b0;
    end else begin
      st2_valid_r <= st1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    st2_compute_r <= st1_compute_r;
    st2_wr_ok_r   <= wr_ok_nxt;
    st2_ux_r      <= ux_nxt;
    st2_uy_r      <= uy_nxt;
    st2_value_r   <= PIXEL_BITS'(st1_value_r);
    st2_col_r     <= IDX_W'(st1_col_r);
    st2_row_r     <= IDX_W'(st1_row_r);
  end

  logic [SZ_W-1:0] size_w, size_h;
  axis_t           ax_nxt, ay_nxt;

  always_comb begin
    if (cfg_src_w_r == '0) begin
      size_w = SZ_W'(1);
    end else if (32'(cfg_src_w_r) > MAX_DIM) begin
      size_w = MAX_SZ;
    end else begin
      size_w = SZ_W'(cfg_src_w_r);
    end
    if (cfg_src_h_r == '0) begin
      size_h = SZ_W'(1);
    end else if (32'(cfg_src_h_r) > MAX_DIM) begin
      size_h = MAX_SZ;
    end else begin
      size_h = SZ_W'(cfg_src_h_r);
    end
  end

  assign ax_nxt = axis_sample(st2_ux_r, size_w);
  assign ay_nxt = axis_sample(st2_uy_r, size_h);

  // ---------------- stage 3: bank access ----------------
  logic                  st3_valid_r, st3_compute_r, st3_wr_ok_r;
  axis_t                 st3_ax_r, st3_ay_r;
  logic [PIXEL_BITS-1:0] st3_value_r;
  logic [IDX_W-1:0]      st3_col_r, st3_row_r;
  logic                  st3_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st3_valid_r <= 1'b0;
    end else begin
      st3_valid_r <= st2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    st3_compute_r <= st2_compute_r;
    st3_wr_ok_r   <= st2_wr_ok_r;
    st3_ax_r      <= ax_nxt;
    st3_ay_r      <= ay_nxt;
    st3_value_r   <= st2_value_r;
    st3_col_r     <= st2_col_r;
    st3_row_r     <= st2_row_r;
  end

  assign st3_wr = st3_valid_r && !st3_compute_r && st3_wr_ok_r;

  // neighbours i0 and i1 are equal or adjacent, so each parity bank is read once
  logic [PIXEL_BITS-1:0] bank_rd [4];

  for (genvar rp = 0; rp < 2; rp++) begin : g_row
    for (genvar cp = 0; cp < 2; cp++) begin : g_col
      logic [PIXEL_BITS-1:0] bank_mem [BANK_DEPTH];
      logic [PIXEL_BITS-1:0] rd_r;
      logic [IDX_W-1:0]      rrow, rcol;
      logic [2*HALF_W-1:0]   raddr, waddr;
      logic                  hit;

      assign rrow  = (st3_ay_r.i0[0] == 1'(rp)) ? st3_ay_r.i0 : st3_ay_r.i1;
      assign rcol  = (st3_ax_r.i0[0] == 1'(cp)) ? st3_ax_r.i0 : st3_ax_r.i1;
      assign raddr = {HALF_W'(rrow >> 1), HALF_W'(rcol >> 1)};
      assign waddr = {HALF_W'(st3_row_r >> 1), HALF_W'(st3_col_r >> 1)};
      assign hit   = st3_wr && (st3_row_r[0] == 1'(rp)) && (st3_col_r[0] == 1'(cp));

      always_ff @(posedge clk) begin
        if (hit) begin
          bank_mem[waddr] <= st3_value_r;
        end
        rd_r <= bank_mem[raddr];
      end

      assign bank_rd[2*rp+cp] = rd_r;
    end
  end

  // ---------------- stage 4: row blend ----------------
  logic                 st4_valid_r;
  logic                 st4_x0p_r, st4_x1p_r, st4_y0p_r, st4_y1p_r;
  logic [FRAC_BITS-1:0] st4_wx_r, st4_wy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st4_valid_r <= 1'b0;
    end else begin
      st4_valid_r <= st3_valid_r && st3_compute_r;
    end
  end

  always_ff @(posedge clk) begin
    st4_x0p_r <= st3_ax_r.i0[0];
    st4_x1p_r <= st3_ax_r.i1[0];
    st4_y0p_r <= st3_ay_r.i0[0];
    st4_y1p_r <= st3_ay_r.i1[0];
    st4_wx_r  <= st3_ax_r.w;
    st4_wy_r  <= st3_ay_r.w;
  end

  logic [PIXEL_BITS-1:0] pix00, pix01, pix10, pix11;
  logic [FRAC_BITS:0]    gx;
  logic [V_W:0]          pa, pb, pc, pd;
  logic [V_W:0]          v0_sum, v1_sum;

  assign pix00  = bank_rd[{st4_y0p_r, st4_x0p_r}];
  assign pix01  = bank_rd[{st4_y0p_r, st4_x1p_r}];
  assign pix10  = bank_rd[{st4_y1p_r, st4_x0p_r}];
  assign pix11  = bank_rd[{st4_y1p_r, st4_x1p_r}];
  assign gx     = ONE_W - {1'b0, st4_wx_r};
  assign pa     = pix00 * gx;
  assign pb     = pix01 * st4_wx_r;
  assign pc     = pix10 * gx;
  assign pd     = pix11 * st4_wx_r;
  assign v0_sum = pa + pb;
  assign v1_sum = pc + pd;

  // ---------------- stage 5: column partial products ----------------
  logic                 st5_valid_r;
  logic [V_W-1:0]       st5_v0_r, st5_v1_r;
  logic [FRAC_BITS-1:0] st5_wy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st5_valid_r <= 1'b0;
    end else begin
      st5_valid_r <= st4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    st5_v0_r <= v0_sum[V_W-1:0];
    st5_v1_r <= v1_sum[V_W-1:0];
    st5_wy_r <= st4_wy_r;
  end

  // row results split at the weight point keep each multiplier narrow
  logic [FRAC_BITS:0]           gy;
  logic [PIXEL_BITS+FRAC_BITS:0] ph0_nxt;
  logic [PIXEL_BITS+FRAC_BITS-1:0] ph1_nxt;
  logic [2*FRAC_BITS:0]         pl0_nxt;
  logic [2*FRAC_BITS-1:0]       pl1_nxt;

  assign gy      = ONE_W - {1'b0, st5_wy_r};
  assign ph0_nxt = st5_v0_r[V_W-1:FRAC_BITS] * gy;
  assign ph1_nxt = st5_v1_r[V_W-1:FRAC_BITS] * st5_wy_r;
  assign pl0_nxt = st5_v0_r[FRAC_BITS-1:0] * gy;
  assign pl1_nxt = st5_v1_r[FRAC_BITS-1:0] * st5_wy_r;

  // ---------------- stage 6: sum, round, saturate ----------------
  logic                            st6_valid_r;
  logic [PIXEL_BITS+FRAC_BITS:0]   st6_ph0_r;
  logic [PIXEL_BITS+FRAC_BITS-1:0] st6_ph1_r;
  logic [2*FRAC_BITS:0]            st6_pl0_r;
  logic [2*FRAC_BITS-1:0]          st6_pl1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st6_valid_r <= 1'b0;
    end else begin
      st6_valid_r <= st5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    st6_ph0_r <= ph0_nxt;
    st6_ph1_r <= ph1_nxt;
    st6_pl0_r <= pl0_nxt;
    st6_pl1_r <= pl1_nxt;
  end

  logic [PIXEL_BITS+FRAC_BITS:0] hi_sum;
  logic [ACC_W-1:0]              acc;
  logic [ACC_W:0]                rnd;
  logic [RES_W-1:0]              res;
  logic [PIXEL_BITS-1:0]         pixel_nxt;

  assign hi_sum    = st6_ph0_r + (PIXEL_BITS+FRAC_BITS+1)'(st6_ph1_r);
  assign acc       = (ACC_W'(hi_sum) << FRAC_BITS) + ACC_W'(st6_pl0_r)
                   + ACC_W'(st6_pl1_r);
  assign rnd       = {1'b0, acc} + RND_HALF;
  assign res       = rnd[ACC_W:2*FRAC_BITS];
  assign pixel_nxt = (res > PIX_MAX) ? {PIXEL_BITS{1'b1}} : PIXEL_BITS'(res);

  logic             out_valid_r;
  logic [OUT_W-1:0] out_pixel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= st6_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_pixel_r <= OUT_W'(pixel_nxt);
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;

  // ---------------- assertions ----------------
  a_compute_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_opcode == OP_COMPUTE) |-> ##7 out_valid)
    else $error("compute request did not produce a result after seven edges");

  a_load_gives_nothing: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_opcode == OP_LOAD) |-> ##7 !out_valid)
    else $error("load request produced a result");

  a_col_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
    st3_valid_r && st3_compute_r |->
      (st3_ax_r.i1 == st3_ax_r.i0) || (st3_ax_r.i1 == st3_ax_r.i0 + IDX_W'(1)))
    else $error("column neighbours collide in one parity bank");

  a_row_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
    st3_valid_r && st3_compute_r |->
      (st3_ay_r.i1 == st3_ay_r.i0) || (st3_ay_r.i1 == st3_ay_r.i0 + IDX_W'(1)))
    else $error("row neighbours collide in one parity bank");

endmodule

>>> test/bilinear_image_resize_tb.sv
// bilinear_image_resize_tb: self-checking bench for the bilinear image scaler
// predicts every interpolated pixel from a shadow frame store and register copy
// depends on bir_pkg and bilinear_image_resize
module bilinear_image_resize_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bir_pkg::*;

  localparam int MAX_DIM    = DEF_MAX_DIM;
  localparam int PIXEL_BITS = DEF_PIXEL_BITS;
  localparam int FRAC_BITS  = DEF_FRAC_BITS;
  localparam longint unsigned PIX_MAX = (64'd1 << PIXEL_BITS) - 1;

  localparam int SETTLE_CYCLES = 12;   // longer than the pipeline is deep
  localparam int QUIET_LIMIT   = 1000;
  localparam int ITEM_TARGET   = 1550;
  localparam logic [CFG_DATA_W-1:0] STEP_MAX = 32'd67108864;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_opcode;
  logic [LOAD_VAL_W-1:0] in_load_value;
  logic [LOAD_IDX_W-1:0] in_load_col;
  logic [LOAD_IDX_W-1:0] in_load_row;
  logic [DEST_W-1:0]     in_dest_col;
  logic [DEST_W-1:0]     in_dest_row;
  logic                  out_valid;
  logic [OUT_W-1:0]      out_pixel;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // shadow registers, the pixels loaded so far and the results still expected
  logic [SIZE_W-1:0]     src_w_q;
  logic [SIZE_W-1:0]     src_h_q;
  logic [STEP_W-1:0]     step_x_q;
  logic [STEP_W-1:0]     step_y_q;
  logic [PIXEL_BITS-1:0] loaded [int];
  logic [OUT_W-1:0]      pending_pixels [$];

  int fail_count;
  int items_sent;
  int quiet_cycles;
  int calm_left;

  bilinear_image_resize #(
    .MAX_DIM    (MAX_DIM),
    .PIXEL_BITS (PIXEL_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_opcode     (in_opcode),
    .in_load_value (in_load_value),
    .in_load_col   (in_load_col),
    .in_load_row   (in_load_row),
    .in_dest_col   (in_dest_col),
    .in_dest_row   (in_dest_row),
    .out_valid     (out_valid),
    .out_pixel     (out_pixel),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- predictor ----------------

  function automatic int active_size(logic [SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > MAX_DIM) return MAX_DIM;
    return int'(s);
  endfunction

  function automatic int clamp_tap(longint idx, int size);
    if (idx < 0) return 0;
    if (idx >= size) return size - 1;
    return int'(idx);
  endfunction

  // position (d + 0.5) * step - 0.5 in q16: floor is the first tap, low bits the weight
  function automatic void axis_taps(input logic [DEST_W-1:0] d, input logic [STEP_W-1:0] step,
                                    input int size, output int i0, output int i1,
                                    output longint unsigned w);
    longint unsigned dd, ss, twice_pos, pos_plus_one, frac;
    longint base;
    dd = d;
    ss = step;
    twice_pos = (2 * dd + 1) * ss;
    pos_plus_one = (twice_pos + Q_ONE) >> 1;
    base = longint'(pos_plus_one >> Q_FRAC) - 1;
    frac = pos_plus_one & (Q_ONE - 1);
    if (FRAC_BITS <= Q_FRAC) w = frac >> (Q_FRAC - FRAC_BITS);
    else w = frac << (FRAC_BITS - Q_FRAC);
    i0 = clamp_tap(base, size);
    i1 = clamp_tap(base + 1, size);
  endfunction

  function automatic int store_key(int row, int col);
    return row * MAX_DIM + col;
  endfunction

  function automatic longint unsigned tap_value(int row, int col);
    if (!loaded.exists(store_key(row, col))) return 0;
    return loaded[store_key(row, col)];
  endfunction

  function automatic bit taps_loaded(logic [DEST_W-1:0] dc, logic [DEST_W-1:0] dr);
    int x0, x1, y0, y1;
    longint unsigned fx, fy;
    axis_taps(dc, step_x_q, active_size(src_w_q), x0, x1, fx);
    axis_taps(dr, step_y_q, active_size(src_h_q), y0, y1, fy);
    return loaded.exists(store_key(y0, x0)) && loaded.exists(store_key(y0, x1)) &&
           loaded.exists(store_key(y1, x0)) && loaded.exists(store_key(y1, x1));
  endfunction

  function automatic logic [OUT_W-1:0] interpolate_pixel(logic [DEST_W-1:0] dc,
                                                         logic [DEST_W-1:0] dr);
    int x0, x1, y0, y1;
    longint unsigned fx, fy, one_w, top, bottom, acc;
    one_w = 64'd1 << FRAC_BITS;
    axis_taps(dc, step_x_q, active_size(src_w_q), x0, x1, fx);
    axis_taps(dr, step_y_q, active_size(src_h_q), y0, y1, fy);
    top    = tap_value(y0, x0) * (one_w - fx) + tap_value(y0, x1) * fx;
    bottom = tap_value(y1, x0) * (one_w - fx) + tap_value(y1, x1) * fx;
    acc = top * (one_w - fy) + bottom * fy;
    acc = (acc + (64'd1 << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
    if (acc > PIX_MAX) acc = PIX_MAX;
    return acc[OUT_W-1:0];
  endfunction

  // ---------------- result checking and watchdog ----------------

  always @(posedge clk) begin : result_check
    logic [OUT_W-1:0] want;
    if (rst_n && out_valid) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t unexpected pixel: expected none, actual %0d", $time, out_pixel);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_pixel !== want) begin
          $display("%0t pixel mismatch: expected %0d, actual %0d", $time, want, out_pixel);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t watchdog: nothing accepted for %0d cycles", $time, QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------- request side ----------------

  task automatic issue_request(opcode_t op, logic [LOAD_VAL_W-1:0] value,
                               logic [LOAD_IDX_W-1:0] col, logic [LOAD_IDX_W-1:0] row,
                               logic [DEST_W-1:0] dc, logic [DEST_W-1:0] dr);
    int gap;
    start         <= 1'b1;
    in_opcode     <= op;
    in_load_value <= value;
    in_load_col   <= col;
    in_load_row   <= row;
    in_dest_col   <= dc;
    in_dest_row   <= dr;
    do @(posedge clk); while (busy !== 1'b0);
    items_sent++;
    if (op == OP_LOAD) begin
      if (col < MAX_DIM && row < MAX_DIM)
        loaded[store_key(int'(row), int'(col))] = PIXEL_BITS'(value);
    end else begin
      pending_pixels = {pending_pixels, interpolate_pixel(dc, dr)};
    end
    // start stays high when the next request follows at once
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      case ($urandom_range(0, 19))
        0:                gap = 0;
        1, 2:             gap = $urandom_range(5, 40);
        3, 4, 5, 6, 7, 8: gap = $urandom_range(1, 3);
        default:          gap = 0;
      endcase
      if (gap == 0 && $urandom_range(0, 19) == 0) calm_left = $urandom_range(20, 80);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic try_compute(logic [DEST_W-1:0] dc, logic [DEST_W-1:0] dr);
    // never sample a store entry that was not loaded
    if (taps_loaded(dc, dr))
      issue_request(OP_COMPUTE, LOAD_VAL_W'($urandom()), LOAD_IDX_W'($urandom()),
                    LOAD_IDX_W'($urandom()), dc, dr);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    // loads leave no result, so give the pipeline time to finish them
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [LOAD_VAL_W-1:0] pixel_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return LOAD_VAL_W'($urandom());
    endcase
  endfunction

  task automatic load_region(int w, int h);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++)
        issue_request(OP_LOAD, pixel_value(), LOAD_IDX_W'(c), LOAD_IDX_W'(r),
                      DEST_W'($urandom()), DEST_W'($urandom()));
  endtask

  // ---------------- configuration port ----------------

  task automatic apb_transfer(bit wr, cfg_reg_t idx, logic [CFG_DATA_W-1:0] wdata,
                              output logic [CFG_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] unused;
    apb_transfer(1'b1, idx, value, unused);
    case (idx)
      REG_SRC_W:  src_w_q  = value[SIZE_W-1:0];
      REG_SRC_H:  src_h_q  = value[SIZE_W-1:0];
      REG_STEP_X: step_x_q = value[STEP_W-1:0];
      REG_STEP_Y: step_y_q = value[STEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic check_reg(cfg_reg_t idx);
    logic [CFG_DATA_W-1:0] want, got;
    case (idx)
      REG_SRC_W:  want = CFG_DATA_W'(src_w_q);
      REG_SRC_H:  want = CFG_DATA_W'(src_h_q);
      REG_STEP_X: want = CFG_DATA_W'(step_x_q);
      default:    want = CFG_DATA_W'(step_y_q);
    endcase
    apb_transfer(1'b0, idx, '0, got);
    if (got !== want) begin
      $display("%0t register %s readback: expected %0h, actual %0h",
               $time, idx.name(), want, got);
      fail_count++;
    end
  endtask

  task automatic set_scale(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                           logic [CFG_DATA_W-1:0] sx, logic [CFG_DATA_W-1:0] sy);
    wait_drained();
    write_reg(REG_SRC_W, w);
    write_reg(REG_SRC_H, h);
    write_reg(REG_STEP_X, sx);
    write_reg(REG_STEP_Y, sy);
    check_reg(REG_SRC_W);
    check_reg(REG_SRC_H);
    check_reg(REG_STEP_X);
    check_reg(REG_STEP_Y);
  endtask

  // ---------------- tests ----------------

  task automatic test_register_access();
    // reset values first, then all-ones (upper bits must drop) and all-zeros
    check_reg(REG_SRC_W);
    check_reg(REG_SRC_H);
    check_reg(REG_STEP_X);
    check_reg(REG_STEP_Y);
    set_scale('1, '1, '1, '1);
    set_scale('0, '0, '0, '0);
  endtask

  task automatic test_default_scale();
    set_scale(RST_SIZE, RST_SIZE, RST_STEP, RST_STEP);
    issue_request(OP_LOAD, 16'hFFFF, 0, 0, '1, '1);
    try_compute(0, 0);
    try_compute(16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_small_image_corner_cases();
    // half weight on both axes, columns 0 and 1 on row 0 only, must round up
    set_scale(2, 2, 2 * RST_STEP, 0);
    issue_request(OP_LOAD, 16'h0000, 0, 0, 0, 0);
    issue_request(OP_LOAD, 16'h0001, 1, 0, 0, 0);
    issue_request(OP_LOAD, 16'hFFFF, 0, 1, 0, 0);
    issue_request(OP_LOAD, 16'hFFFE, 1, 1, 0, 0);
    try_compute(0, 0);
    // two times upscale, past the far edge too
    set_scale(2, 2, RST_STEP / 2, RST_STEP / 2);
    try_compute(0, 0);
    try_compute(3, 3);
    try_compute(16'hFFFF, 16'hFFFF);
    // zero step pins every position to the first pixel
    set_scale(2, 2, 0, 0);
    try_compute(5, 9);
    // zero size behaves as a single pixel
    set_scale(0, 0, RST_STEP, RST_STEP);
    try_compute(1, 1);
    // step extremes on each axis
    set_scale(2, 2, STEP_MAX, 1);
    try_compute(16'hFFFF, 1);
    set_scale(2, 2, 1, STEP_MAX);
    try_compute(2, 16'hFFFF);
  endtask

  task automatic test_oversized_source();
    // a size past the store limit acts as the full store
    set_scale(2047, 2047, RST_STEP / 2, RST_STEP / 2);
    issue_request(OP_LOAD, pixel_value(), 0, 0, 0, 0);
    issue_request(OP_LOAD, pixel_value(), LOAD_IDX_W'(MAX_DIM - 1),
                  LOAD_IDX_W'(MAX_DIM - 1), 0, 0);
    try_compute(0, 0);
    try_compute(16'hFFFF, 16'hFFFF);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_step(int src, int dst);
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return 1;
      2:       return STEP_MAX;
      3:       return (32'd1 << STEP_W) - 1;
      4:       return $urandom_range(1, STEP_MAX);
      5, 6:    return $urandom_range(RST_STEP / 2, 4 * RST_STEP);
      default: return (src << Q_FRAC) / dst;
    endcase
  endfunction

  task automatic test_random_scaling();
    int raw_w, raw_h, w, h, dst_w, dst_h, n;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: begin
          raw_w = $urandom_range(0, 1);
          raw_h = $urandom_range(0, 64);
        end
        1: begin
          raw_w = $urandom_range(17, 64);
          raw_h = $urandom_range(0, 4);
        end
        default: begin
          raw_w = $urandom_range(1, 16);
          raw_h = $urandom_range(1, 16);
        end
      endcase
      w = active_size(SIZE_W'(raw_w));
      h = active_size(SIZE_W'(raw_h));
      dst_w = $urandom_range(1, 4 * w);
      dst_h = $urandom_range(1, 4 * h);
      set_scale(raw_w, raw_h, pick_step(w, dst_w), pick_step(h, dst_h));
      load_region(w, h);
      n = $urandom_range(60, 180);
      for (int k = 0; k < n && items_sent < ITEM_TARGET; k++) begin
        case ($urandom_range(0, 39))
          0, 1, 2:
            issue_request(OP_LOAD, pixel_value(), LOAD_IDX_W'($urandom()),
                          LOAD_IDX_W'($urandom()), DEST_W'($urandom()),
                          DEST_W'($urandom()));
          3, 4, 5:
            issue_request(OP_LOAD, pixel_value(), LOAD_IDX_W'($urandom_range(0, w - 1)),
                          LOAD_IDX_W'($urandom_range(0, h - 1)), DEST_W'($urandom()),
                          DEST_W'($urandom()));
          6, 7, 8, 9:
            try_compute(DEST_W'($urandom()), DEST_W'($urandom()));
          10:
            try_compute('1, DEST_W'($urandom_range(0, dst_h)));
          11:
            wait_drained();
          default:
            try_compute(DEST_W'($urandom_range(0, dst_w)), DEST_W'($urandom_range(0, dst_h)));
        endcase
      end
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_opcode     <= OP_LOAD;
    in_load_value <= '0;
    in_load_col   <= '0;
    in_load_row   <= '0;
    in_dest_col   <= '0;
    in_dest_row   <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    src_w_q        = SIZE_W'(RST_SIZE);
    src_h_q        = SIZE_W'(RST_SIZE);
    step_x_q       = STEP_W'(RST_STEP);
    step_y_q       = STEP_W'(RST_STEP);
    fail_count     = 0;
    items_sent     = 0;
    calm_left      = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_access();
    test_default_scale();
    test_small_image_corner_cases();
    test_oversized_source();
    test_random_scaling();
    wait_drained();

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/bir_pkg.sv
rtl/bilinear_image_resize.sv
test/bilinear_image_resize_tb.sv
